### hw/rtl/vdma_pkg.sv
package vdma_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_REG_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK      = 2'd1;
    localparam logic [1:0] CMD_HBLANK    = 2'd2;

    // Register offsets
    localparam logic [7:0] OFF_SRC_HI = 8'h51;
    localparam logic [7:0] OFF_SRC_LO = 8'h52;
    localparam logic [7:0] OFF_DST_HI = 8'h53;
    localparam logic [7:0] OFF_DST_LO = 8'h54;
    localparam logic [7:0] OFF_START  = 8'h55;

    // Address constants
    localparam logic [15:0] SRC_RESET  = 16'h9FF0;
    localparam logic [15:0] DST_RESET  = 16'hDFF0;
    localparam logic [15:0] SRC_MASK   = 16'hFFF0;
    localparam logic [15:0] DST_MASK   = 16'h1FF0;
    localparam logic [15:0] VRAM_BASE  = 16'h8000;
    localparam logic [15:0] ADDR_DONE  = 16'hFFFF;

    localparam int unsigned CNT_W        = 12;
    localparam int unsigned MAX_PER_TICK = 2;
    localparam logic [CNT_W-1:0] BURST_BYTES = 12'h010;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_offset;
        logic [7:0] write_byte;
    } in_item_t;

    typedef struct packed {
        logic        copy_valid;
        logic [15:0] src_addr;
        logic [15:0] dst_addr;
        logic        last;
        logic        busy_res;
        logic [7:0]  length_code;
    } out_item_t;

    // Up to two results produced by one input item; r0.last clear means r1 follows
    typedef struct packed {
        out_item_t r0;
        out_item_t r1;
    } res_pair_t;

    // Length code: remaining total in 16-byte units, minus one, mod 256
    function automatic logic [7:0] len_code(input logic [CNT_W-1:0] total);
        return total[CNT_W-1:4] - 8'd1;
    endfunction

    function automatic logic [CNT_W-1:0] min_burst(input logic [CNT_W-1:0] total);
        return (total < BURST_BYTES) ? total : BURST_BYTES;
    endfunction

endpackage

### hw/rtl/video_dma_controller.sv
// Video DMA controller. Each input item is a register write (offsets 0x51-0x54 load the
// source and destination address bytes, 0x55 starts a general or HBlank transfer or
// cancels a running HBlank transfer), a transfer tick, or an HBlank event. A tick with a
// burst pending gives up to two copy commands (source address, VRAM destination);
// every other item gives one status result. Every result carries the burst busy flag and
// the remaining length code; the final result of an item has last set. The single result
// port shows one result per cycle while m_ready is high, so a tick that gives two results
// shows them in turn. The first result passes through the input register, then the result
// register, and a new item is taken while an earlier result still waits for m_ready. When a
// transfer completes, both address registers read 0xFFFF.
module video_dma_controller #(
    parameter int unsigned BYTES_PER_TICK = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vdma_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output vdma_pkg::out_item_t m_item
);
    import vdma_pkg::*;

    logic      pair_valid;
    logic      pair_ready;
    res_pair_t pair;

    // Register decode, transfer state and copy address generation
    vdma_core #(
        .BYTES_PER_TICK(BYTES_PER_TICK)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair      (pair)
    );

    // Result register, one result per cycle while m_ready is high
    vdma_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair      (pair),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

### hw/rtl/vdma_core.sv
module vdma_core #(
    parameter int unsigned BYTES_PER_TICK = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vdma_pkg::in_item_t s_item,
    output logic               pair_valid,
    input  logic               pair_ready,
    output vdma_pkg::res_pair_t pair
);
    import vdma_pkg::*;

    localparam bit TWO_PER_TICK = (BYTES_PER_TICK >= MAX_PER_TICK);

    // Input register
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    logic     take;

    // Transfer state
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic             hblank_reg, hblank_next;
    logic [CNT_W-1:0] burst_reg, burst_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] done_reg, done_next;

    // Tick datapath
    logic [15:0]      src_base, dst_base;
    logic [CNT_W-1:0] burst_m1, burst_m2, total_m1, total_m2;
    logic             tick_copy, tick_two;
    logic [CNT_W-1:0] start_total;
    logic             is_cancel;

    assign take          = in_valid_reg && pair_ready;
    assign s_ready       = !in_valid_reg || take;
    assign pair_valid    = in_valid_reg;
    assign in_valid_next = s_valid && s_ready ? 1'b1 : (take ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Copy addresses and counter decrements
    assign src_base  = (src_reg & SRC_MASK) + {4'd0, done_reg};
    assign dst_base  = ((dst_reg & DST_MASK) | VRAM_BASE) + {4'd0, done_reg};
    assign burst_m1  = burst_reg - 12'd1;
    assign burst_m2  = burst_reg - 12'd2;
    assign total_m1  = total_reg - 12'd1;
    assign total_m2  = total_reg - 12'd2;
    assign tick_copy = (in_item_reg.cmd == CMD_TICK) && (burst_reg != '0);
    assign tick_two  = tick_copy && TWO_PER_TICK && (burst_m1 != '0);

    assign start_total = {({1'b0, in_item_reg.write_byte[6:0]} + 8'd1), 4'd0};
    assign is_cancel   = hblank_reg && (total_reg != '0) && !in_item_reg.write_byte[7];

    // Next state
    always_comb begin
        src_next    = src_reg;
        dst_next    = dst_reg;
        hblank_next = hblank_reg;
        burst_next  = burst_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        case (in_item_reg.cmd)
            CMD_REG_WRITE: begin
                case (in_item_reg.reg_offset)
                    OFF_SRC_HI: src_next = {in_item_reg.write_byte, src_reg[7:0]};
                    OFF_SRC_LO: src_next = {src_reg[15:8], in_item_reg.write_byte};
                    OFF_DST_HI: dst_next = {in_item_reg.write_byte, dst_reg[7:0]};
                    OFF_DST_LO: dst_next = {dst_reg[15:8], in_item_reg.write_byte};
                    OFF_START: begin
                        if (is_cancel) begin
                            total_next = '0;
                            burst_next = '0;
                        end else begin
                            done_next   = '0;
                            hblank_next = in_item_reg.write_byte[7];
                            total_next  = start_total;
                            burst_next  = in_item_reg.write_byte[7] ?
                                          min_burst(start_total) : start_total;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (tick_copy) begin
                    if (tick_two) begin
                        burst_next = burst_m2;
                        total_next = total_m2;
                        done_next  = done_reg + 12'd2;
                    end else begin
                        burst_next = burst_m1;
                        total_next = total_m1;
                        done_next  = done_reg + 12'd1;
                    end
                    if (total_next == '0) begin
                        src_next = ADDR_DONE;
                        dst_next = ADDR_DONE;
                    end
                end
            end
            CMD_HBLANK: begin
                if (hblank_reg) begin
                    burst_next = min_burst(total_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg    <= SRC_RESET;
            dst_reg    <= DST_RESET;
            hblank_reg <= 1'b0;
            burst_reg  <= '0;
            total_reg  <= '0;
            done_reg   <= '0;
        end else if (take) begin
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            hblank_reg <= hblank_next;
            burst_reg  <= burst_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
        end
    end

    // Result pair
    always_comb begin
        if (tick_copy) begin
            pair.r0.copy_valid  = 1'b1;
            pair.r0.src_addr    = src_base;
            pair.r0.dst_addr    = dst_base;
            pair.r0.last        = !tick_two;
            pair.r0.busy_res    = (burst_m1 != '0);
            pair.r0.length_code = len_code(total_m1);
        end else begin
            pair.r0.copy_valid  = 1'b0;
            pair.r0.src_addr    = '0;
            pair.r0.dst_addr    = '0;
            pair.r0.last        = 1'b1;
            pair.r0.busy_res    = (burst_next != '0);
            pair.r0.length_code = len_code(total_next);
        end
        pair.r1.copy_valid  = 1'b1;
        pair.r1.src_addr    = src_base + 16'd1;
        pair.r1.dst_addr    = dst_base + 16'd1;
        pair.r1.last        = 1'b1;
        pair.r1.busy_res    = (burst_m2 != '0);
        pair.r1.length_code = len_code(total_m2);
    end

endmodule

### hw/rtl/vdma_out.sv
module vdma_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pair_valid,
    output logic                pair_ready,
    input  vdma_pkg::res_pair_t pair,
    output logic                m_valid,
    input  logic                m_ready,
    output vdma_pkg::out_item_t m_item
);
    import vdma_pkg::*;

    logic      busy_reg, busy_next;
    logic      idx_reg, idx_next;
    res_pair_t pair_reg;
    logic      load;
    logic      head_done;

    // Show the first result, then the second of a pair
    assign m_item     = idx_reg ? pair_reg.r1 : pair_reg.r0;
    assign m_valid    = busy_reg;
    assign head_done  = busy_reg && m_ready && m_item.last;
    assign pair_ready = !busy_reg || head_done;
    assign load       = pair_valid && pair_ready;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 1'b0;
        end else if (head_done) begin
            busy_next = 1'b0;
        end else if (busy_reg && m_ready) begin
            idx_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        if (load) begin
            pair_reg <= pair;
        end
    end

endmodule

### hw/rtl/vdma_checker.sv
module vdma_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input vdma_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input vdma_pkg::out_item_t m_item
);
    import vdma_pkg::*;

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // Status results carry zero addresses and close their item
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.copy_valid |->
            m_item.last && m_item.src_addr == 16'd0 && m_item.dst_addr == 16'd0)
        else $error("bad status result");

    // The first copy of a pair leaves the burst busy
    a_first_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.copy_valid && !m_item.last |-> m_item.busy_res)
        else $error("first copy of a pair ends the burst");

    // The second copy of a pair follows at the next addresses
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.copy_valid && !m_item.last |=>
            m_valid && m_item.copy_valid && m_item.last &&
            m_item.src_addr == $past(m_item.src_addr) + 16'd1 &&
            m_item.dst_addr == $past(m_item.dst_addr) + 16'd1)
        else $error("second copy out of sequence");

endmodule

bind video_dma_controller vdma_checker u_vdma_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_item (s_item),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);
